### hw/rtl/aftms_pkg.sv
// Shared types, widths and constants for the audio frame to tick scheduler.
`default_nettype none

package aftms_pkg;

    localparam int FRAME_W = 32;
    localparam int BUF_W   = 14;
    localparam int RATE_W  = 18;
    localparam int PPQ_W   = 10;
    localparam int QLEN_W  = 22;
    localparam int US_W    = 20;
    localparam int TICK_W  = 32;
    localparam int OFF_W   = 13;
    localparam int CFG_W   = 22;
    localparam int CFG_IDX_W = 2;

    localparam int PDEN_W = PPQ_W + US_W;
    localparam int DEN_W  = RATE_W + QLEN_W;
    localparam int NUM_W  = FRAME_W + PDEN_W;
    localparam int TW     = NUM_W + 1;
    localparam int PW     = TW + DEN_W;

    localparam logic [US_W-1:0] US_PER_SECOND = US_W'(1000000);

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);
    localparam logic [PPQ_W-1:0]  PPQ_RESET  = PPQ_W'(192);
    localparam logic [QLEN_W-1:0] QLEN_RESET = QLEN_W'(500000);

    localparam int DEF_MAX_TICKS  = 64;
    localparam int DEF_MAX_FRAMES = 8192;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_RATE = 2'd0,
        CFG_PPQ         = 2'd1,
        CFG_QLEN        = 2'd2
    } t_cfg_idx;

    typedef enum logic [0:0] {
        KIND_TICK  = 1'b0,
        KIND_FLUSH = 1'b1
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DIV0,
        S_WAIT0,
        S_ADJ,
        S_DIVT,
        S_WAITT,
        S_CHECK,
        S_EMIT,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [FRAME_W-1:0] start_frame;
        logic [BUF_W-1:0]   buffer_frames;
        logic               stopped;
    } t_in;

    typedef struct packed {
        logic               kind;
        logic [TICK_W-1:0]  tick_number;
        logic [OFF_W-1:0]   frame_offset;
        logic               last;
        logic               truncated;
    } t_out;

    typedef struct packed {
        logic done;
        logic rem_nz;
    } t_div_stat;

endpackage

`default_nettype wire

### hw/rtl/audio_frame_to_midi_tick_scheduler.sv
// Top level: converts audio buffer positions into sequencer tick results.
//
// Input channel (i_valid, o_stall, i_in) takes one audio buffer: start frame,
// length and stopped flag. Output channel (o_valid, i_stall, o_out) gives
// the results: one per tick in the buffer, or one flush item after a stop.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once; the
// user is to make them while the block is idle, as the block itself does not enforce this.
// One buffer is worked on at a time; o_stall is high until it is finished.
// A running buffer first forms the start-frame product by shift and add, then
// runs the serial division for the first tick and one more for every tick
// frame checked, and hands each tick to the output; the single serial divider
// is shared by all these divisions. A stopped buffer after a running one
// passes through the flush state, waiting there while the output is stalled.
// Each tick result is sent once the following tick has been checked, so that
// the final one carries last (and truncated when the tick limit was hit).
// A single output register holds a result while i_stall is high; the block
// waits for it to drain before loading the next result.
// Reset restores the default tempo settings, clears the tick counter and
// the running flag; there is no clearing pass.
`default_nettype none

module audio_frame_to_midi_tick_scheduler #(
    parameter int MAX_TICKS_PER_BUFFER = aftms_pkg::DEF_MAX_TICKS,
    parameter int MAX_BUFFER_FRAMES    = aftms_pkg::DEF_MAX_FRAMES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  aftms_pkg::t_in                  i_in,
    output logic                            o_valid,
    input  logic                            i_stall,
    output aftms_pkg::t_out                 o_out,
    input  logic                            i_cfg_we,
    input  logic [aftms_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [aftms_pkg::CFG_W-1:0]     i_cfg_data
);
    import aftms_pkg::*;

    localparam int CW    = $clog2(MAX_TICKS_PER_BUFFER + 1);
    localparam int MCW   = $clog2(FRAME_W + 1);

    t_state r_state, n_state;

    logic [RATE_W-1:0]  r_rate;
    logic [PPQ_W-1:0]   r_ppq;
    logic [QLEN_W-1:0]  r_qlen;

    logic               r_was_running;
    logic [TICK_W-1:0]  r_cur_tick;

    logic [FRAME_W-1:0] r_frame;
    logic [FRAME_W-1:0] r_fsh;
    logic [MCW-1:0]     r_mcnt;
    logic [BUF_W-1:0]   r_n;
    logic [DEN_W-1:0]   r_den;
    logic [PDEN_W-1:0]  r_pden;
    logic [NUM_W-1:0]   r_acc;
    logic [TW-1:0]      r_t;
    logic [PW-1:0]      r_p;
    logic [CW-1:0]      r_count;

    logic               r_pend_valid;
    logic [TICK_W-1:0]  r_pend_tick;
    logic [OFF_W-1:0]   r_pend_off;
    logic [OFF_W-1:0]   r_cand_off;
    logic               r_emit_last;
    logic               r_emit_trunc;

    logic               r_ovalid;
    t_out               r_out;

    logic               acc_in;
    logic               cfg_zero;
    logic               out_free;
    logic [DEN_W-1:0]   den_c;
    logic [PDEN_W-1:0]  pden_c;
    logic [BUF_W-1:0]   n_eff;
    logic [NUM_W-1:0]   n_acc;

    logic [PW-1:0]      div_dividend;
    logic [DEN_W-1:0]   div_divisor;
    logic [PW-1:0]      div_quo;
    logic [DEN_W-1:0]   div_rem;
    t_div_stat          div_stat;

    logic [PW:0]        diff;
    logic [PW-1:0]      off;
    logic               in_buf;
    logic               below_max;
    logic               keep_going;

    logic               c_div_start;
    logic               c_load_tick;
    logic               c_load_flush;
    logic               c_advance;
    logic               c_finish;

    assign acc_in   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;
    assign cfg_zero = (r_rate == '0) || (r_ppq == '0) || (r_qlen == '0);

    always_comb begin
        den_c  = {{QLEN_W{1'b0}}, r_rate} * {{RATE_W{1'b0}}, r_qlen};
        pden_c = {{US_W{1'b0}}, r_ppq} * {{PPQ_W{1'b0}}, US_PER_SECOND};
        if (32'(i_in.buffer_frames) > 32'(MAX_BUFFER_FRAMES)) begin
            n_eff = BUF_W'(MAX_BUFFER_FRAMES);
        end else begin
            n_eff = i_in.buffer_frames;
        end
        n_acc = {r_acc[NUM_W-2:0], 1'b0} + (r_fsh[FRAME_W-1] ? NUM_W'(r_pden) : '0);
    end

    always_comb begin
        diff       = {1'b0, div_quo} - {{(PW + 1 - FRAME_W){1'b0}}, r_frame};
        off        = diff[PW] ? '0 : diff[PW-1:0];
        in_buf     = (off[PW-1:BUF_W] == '0) && (off[BUF_W-1:0] < r_n);
        below_max  = r_count < CW'(MAX_TICKS_PER_BUFFER);
        keep_going = in_buf && below_max;
    end

    assign div_dividend = (r_state == S_DIV0) ? PW'(r_acc) : r_p;
    assign div_divisor  = (r_state == S_DIV0) ? r_den : DEN_W'(r_pden);

    aftms_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (c_div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_quotient  (div_quo),
        .o_remainder (div_rem),
        .o_stat      (div_stat)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    if (i_in.stopped) begin
                        n_state = r_was_running ? S_FLUSH : S_IDLE;
                    end else if (!cfg_zero) begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (r_mcnt == MCW'(1)) begin
                    n_state = S_DIV0;
                end
            end
            S_DIV0:  n_state = S_WAIT0;
            S_WAIT0: begin
                if (div_stat.done) begin
                    n_state = S_ADJ;
                end
            end
            S_ADJ:   n_state = S_DIVT;
            S_DIVT:  n_state = S_WAITT;
            S_WAITT: begin
                if (div_stat.done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_pend_valid) begin
                    n_state = S_EMIT;
                end else if (keep_going) begin
                    n_state = S_DIVT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = r_emit_last ? S_IDLE : S_DIVT;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        c_div_start  = 1'b0;
        c_load_tick  = 1'b0;
        c_load_flush = 1'b0;
        c_advance    = 1'b0;
        c_finish     = 1'b0;
        case (r_state)
            S_DIV0, S_DIVT: c_div_start = 1'b1;
            S_CHECK: begin
                c_advance = keep_going && !r_pend_valid;
                c_finish  = !keep_going;
            end
            S_EMIT: begin
                c_load_tick = out_free;
                c_advance   = out_free && !r_emit_last;
            end
            S_FLUSH: c_load_flush = out_free;
            default: c_div_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_rate        <= RATE_RESET;
            r_ppq         <= PPQ_RESET;
            r_qlen        <= QLEN_RESET;
            r_was_running <= 1'b0;
            r_cur_tick    <= '0;
            r_count       <= '0;
            r_pend_valid  <= 1'b0;
            r_ovalid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SAMPLE_RATE: r_rate <= i_cfg_data[RATE_W-1:0];
                    CFG_PPQ:         r_ppq  <= i_cfg_data[PPQ_W-1:0];
                    CFG_QLEN:        r_qlen <= i_cfg_data[QLEN_W-1:0];
                    default:         r_rate <= r_rate;
                endcase
            end
            if (acc_in) begin
                r_was_running <= !i_in.stopped;
                r_count       <= '0;
                r_pend_valid  <= 1'b0;
            end
            if (c_finish) begin
                r_cur_tick <= r_t[TICK_W-1:0];
            end
            if (c_advance) begin
                r_count      <= r_count + CW'(1);
                r_pend_valid <= 1'b1;
            end else if (c_load_tick) begin
                r_pend_valid <= 1'b0;
            end
            if (c_load_tick || c_load_flush) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_frame <= i_in.start_frame;
            r_fsh   <= i_in.start_frame;
            r_n     <= n_eff;
            r_den   <= den_c;
            r_pden  <= pden_c;
            r_acc   <= '0;
            r_mcnt  <= MCW'(FRAME_W);
        end else if (r_state == S_MUL) begin
            r_acc  <= n_acc;
            r_fsh  <= {r_fsh[FRAME_W-2:0], 1'b0};
            r_mcnt <= r_mcnt - MCW'(1);
        end
        if (r_state == S_ADJ) begin
            r_t <= div_quo[TW-1:0] + TW'(div_stat.rem_nz);
            r_p <= PW'(r_acc) + (div_stat.rem_nz ? PW'(r_den - div_rem) : '0);
        end else if (c_advance) begin
            r_t <= r_t + TW'(1);
            r_p <= r_p + PW'(r_den);
        end
        if (r_state == S_CHECK) begin
            r_cand_off   <= off[OFF_W-1:0];
            r_emit_last  <= !keep_going;
            r_emit_trunc <= in_buf;
        end
        if (c_advance) begin
            r_pend_tick <= r_t[TICK_W-1:0];
            r_pend_off  <= (r_state == S_CHECK) ? off[OFF_W-1:0] : r_cand_off;
        end
        if (c_load_tick) begin
            r_out.kind         <= KIND_TICK;
            r_out.tick_number  <= r_pend_tick;
            r_out.frame_offset <= r_pend_off;
            r_out.last         <= r_emit_last;
            r_out.truncated    <= r_emit_last && r_emit_trunc;
        end else if (c_load_flush) begin
            r_out.kind         <= KIND_FLUSH;
            r_out.tick_number  <= r_cur_tick;
            r_out.frame_offset <= '0;
            r_out.last         <= 1'b1;
            r_out.truncated    <= 1'b0;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_out   = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_TICKS_PER_BUFFER))
        else $error("tick count above limit");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("pending tick left behind at idle");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.kind) |-> (o_out.last && !o_out.truncated))
        else $error("flush item not marked last");

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.truncated) |-> o_out.last)
        else $error("truncated set on a non-final item");

endmodule

`default_nettype wire

### hw/rtl/aftms_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module aftms_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [aftms_pkg::PW-1:0]    i_dividend,
    input  logic [aftms_pkg::DEN_W-1:0] i_divisor,
    output logic [aftms_pkg::PW-1:0]    o_quotient,
    output logic [aftms_pkg::DEN_W-1:0] o_remainder,
    output aftms_pkg::t_div_stat        o_stat
);
    import aftms_pkg::*;

    localparam int CNT_W = $clog2(PW + 1);

    logic [PW-1:0]    r_quo, n_quo;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0] sh;
    logic [DEN_W:0] diff;
    logic           ge;

    always_comb begin
        sh    = {r_rem, r_quo[PW-1]};
        diff  = sh - {1'b0, r_dvs};
        ge    = sh >= {1'b0, r_dvs};
        n_rem = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
        n_quo = {r_quo[PW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(PW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_quotient    = r_quo;
    assign o_remainder   = r_rem;
    assign o_stat.done   = r_done;
    assign o_stat.rem_nz = (r_rem != '0);

endmodule

`default_nettype wire
